// File: rtl/dtw_distance_engine_assert.svh
// assertion macros for the dtw distance engine
// included by the top level, expects clk and rst in scope
`ifndef DTW_DISTANCE_ENGINE_ASSERT_SVH
`define DTW_DISTANCE_ENGINE_ASSERT_SVH

// same-cycle implication, quiet during reset
`define DTW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, quiet during reset
`define DTW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/dtw_pkg.sv
// shared types and constants for the dtw distance engine
// no dependencies; used by dtw_cell, dtw_isqrt, dtw_distance_engine and the testbench
package dtw_pkg;

  localparam int COST_W          = 48;
  localparam int ROOT_W          = 24;
  localparam int SAMPLE_W        = 16;
  localparam int DEF_MAX_LEN     = 256;
  localparam int DEF_SAMPLE_BITS = 16;

  // cost values in the chain carry one extra bit so that infinity sorts above all
  typedef logic [COST_W:0] cost_t;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam cost_t             COST_INF = {1'b1, {COST_W{1'b0}}};

  typedef enum logic {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // flags that travel with one query sample along the chain
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } wave_t;

  // reference write control broadcast to all cells
  typedef struct packed {
    logic en;
    logic clear;
  } wr_ctl_t;

  // finished path cost handed to the root unit
  typedef struct packed {
    logic              valid;
    logic              trunc;
    logic [COST_W-1:0] total;
  } res_t;

endpackage

// File: rtl/dtw_cell.sv
// one cell of the warping chain: holds one reference sample and its column cost
// depends on dtw_pkg
module dtw_cell import dtw_pkg::*; #(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int IDX_W       = 8,
  parameter int CELL_IDX    = 0
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  wr_ctl_t                wr_ctl,
  input  logic [IDX_W-1:0]       wr_idx,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  wave_t                  wave_in,
  input  logic [SAMPLE_BITS-1:0] samp_in,
  output wave_t                  wave_out,
  output logic [SAMPLE_BITS-1:0] samp_out,
  input  cost_t                  left_in,
  input  cost_t                  diag_in,
  output wave_t                  cost_wave,
  output cost_t                  left_out,
  output cost_t                  diag_out
);

  localparam int  SQ_W    = 2 * (SAMPLE_BITS + 1);
  localparam int  SUM_W   = (SQ_W > COST_W + 1 ? SQ_W : COST_W + 1) + 1;
  localparam bit  IS_HEAD = (CELL_IDX == 0);

  logic [SAMPLE_BITS-1:0] a_ref;
  logic                   active;
  wave_t                  sq_wave;
  logic [SQ_W-1:0]        sq;
  logic [COST_W-1:0]      rc;

  logic [SAMPLE_BITS:0]   diff;
  logic [SAMPLE_BITS:0]   mag;
  cost_t                  up;
  cost_t                  diag_eff;
  cost_t                  m1;
  cost_t                  m;
  logic [SUM_W-1:0]       sum;
  logic [COST_W-1:0]      cell_cost;
  logic                   sel;

  assign sel = (wr_idx == IDX_W'(CELL_IDX));

  // absolute difference of query and reference sample
  always_comb begin
    diff = {samp_out[SAMPLE_BITS-1], samp_out} - {a_ref[SAMPLE_BITS-1], a_ref};
    mag  = diff[SAMPLE_BITS] ? (~diff + 1'b1) : diff;
  end

  // minimum of the three neighbours plus local cost, saturating
  always_comb begin
    up       = sq_wave.first ? COST_INF : {1'b0, rc};
    diag_eff = IS_HEAD ? (sq_wave.first ? cost_t'(0) : COST_INF) : diag_in;
    m1       = (up < left_in) ? up : left_in;
    m        = (m1 < diag_eff) ? m1 : diag_eff;
    sum      = SUM_W'(sq) + SUM_W'(m);
    cell_cost = (sum >= SUM_W'(COST_MAX)) ? COST_MAX : sum[COST_W-1:0];
  end

  // control flags
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      wave_out.valid  <= 1'b0;
      sq_wave.valid   <= 1'b0;
      cost_wave.valid <= 1'b0;
    end else begin
      if (wr_ctl.en) begin
        if (sel) begin
          active <= 1'b1;
        end else if (wr_ctl.clear) begin
          active <= 1'b0;
        end
      end
      if (adv) begin
        wave_out.valid  <= wave_in.valid;
        sq_wave.valid   <= wave_out.valid;
        cost_wave.valid <= sq_wave.valid;
      end
    end
  end

  // reference sample store
  always_ff @(posedge clk) begin
    if (wr_ctl.en && sel) begin
      a_ref <= wr_data;
    end
  end

  // sample stage, square stage, cost stage
  always_ff @(posedge clk) begin
    if (adv) begin
      samp_out        <= samp_in;
      wave_out.first  <= wave_in.first;
      wave_out.last   <= wave_in.last;
      sq              <= mag * mag;
      sq_wave.first   <= wave_out.first;
      sq_wave.last    <= wave_out.last;
      cost_wave.first <= sq_wave.first;
      cost_wave.last  <= sq_wave.last;
      if (sq_wave.valid) begin
        if (active) begin
          rc       <= cell_cost;
          left_out <= {1'b0, cell_cost};
          diag_out <= up;
        end else begin
          left_out <= left_in;
          diag_out <= diag_in;
        end
      end
    end
  end

endmodule

// File: rtl/dtw_isqrt.sv
// pipelined floored square root of the path cost, one result bit per stage
// depends on dtw_pkg
module dtw_isqrt import dtw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  res_t              res_in,
  output logic              out_valid,
  output logic [COST_W-1:0] out_total,
  output logic [ROOT_W-1:0] out_root,
  output logic              out_trunc
);

  logic              st_valid [ROOT_W];
  logic              st_trunc [ROOT_W];
  logic [COST_W-1:0] st_total [ROOT_W];
  logic [COST_W-1:0] st_rem   [ROOT_W];
  logic [COST_W-1:0] st_root  [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam logic [COST_W-1:0] BIT_K = COST_W'(1) << (COST_W - 2 - 2 * k);

    logic              p_valid;
    logic              p_trunc;
    logic [COST_W-1:0] p_total;
    logic [COST_W-1:0] p_rem;
    logic [COST_W-1:0] p_root;
    logic [COST_W-1:0] trial;
    logic              take;

    if (k == 0) begin : g_head
      assign p_valid = res_in.valid;
      assign p_trunc = res_in.trunc;
      assign p_total = res_in.total;
      assign p_rem   = res_in.total;
      assign p_root  = '0;
    end else begin : g_body
      assign p_valid = st_valid[k-1];
      assign p_trunc = st_trunc[k-1];
      assign p_total = st_total[k-1];
      assign p_rem   = st_rem[k-1];
      assign p_root  = st_root[k-1];
    end

    // one restoring step
    assign trial = p_root + BIT_K;
    assign take  = (p_rem >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        st_valid[k] <= 1'b0;
      end else if (adv) begin
        st_valid[k] <= p_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        st_trunc[k] <= p_trunc;
        st_total[k] <= p_total;
        st_rem[k]   <= take ? (p_rem - trial) : p_rem;
        st_root[k]  <= take ? ((p_root >> 1) + BIT_K) : (p_root >> 1);
      end
    end
  end

  assign out_valid = st_valid[ROOT_W-1];
  assign out_trunc = st_trunc[ROOT_W-1];
  assign out_total = st_total[ROOT_W-1];
  assign out_root  = st_root[ROOT_W-1][ROOT_W-1:0];

endmodule

// File: rtl/dtw_distance_engine.sv
// dtw distance engine top level: reference control, cell chain, root unit
// depends on dtw_pkg, dtw_cell, dtw_isqrt and dtw_distance_engine_assert.svh
//
//  channel  | handshake           | fields
//  ---------+---------------------+-------------------------------------
//  request  | req_valid/req_stall | opcode, sample, last
//  result   | res_valid/res_stall | dist_sq, dist_root, truncated
//
// a query sample is taken every cycle unless a stalled result holds it; its row runs down
// the chain one cell per cycle, and a result passes the chain registers and then the
// 24-step root pipeline
// a reference append waits until no query sample is left in the chain;
// appends themselves go one per cycle while the result side does not stall
// reset clears control state only; no clearing pass
// a stalled result freezes the chain, the root pipeline and the request side
`include "dtw_distance_engine_assert.svh"

module dtw_distance_engine import dtw_pkg::*; #(
  parameter int MAX_LEN     = DEF_MAX_LEN,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic                opcode,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                last,
  output logic                res_valid,
  input  logic                res_stall,
  output logic [COST_W-1:0]   dist_sq,
  output logic [ROOT_W-1:0]   dist_root,
  output logic                truncated
);

  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int IW = $clog2(MAX_LEN);
  localparam int BW = $clog2(MAX_LEN + 3);

  logic                   adv;
  logic                   acc;
  logic                   app;
  logic                   qry;
  logic                   inject;
  logic                   chain_exit;
  logic [SAMPLE_BITS-1:0] samp_x;

  logic [LW-1:0]          ref_length;
  logic                   ref_closed;
  logic                   ref_overflow;
  logic                   query_started;
  logic [BW-1:0]          busy_cnt;
  logic [BW-1:0]          busy_cnt_next;

  wr_ctl_t                wr_ctl;
  logic [IW-1:0]          wr_idx;
  wave_t                  head_wave;
  res_t                   res_in;

  wave_t                  s_wave [MAX_LEN];
  logic [SAMPLE_BITS-1:0] s_samp [MAX_LEN];
  wave_t                  c_wave [MAX_LEN];
  cost_t                  c_left [MAX_LEN];
  cost_t                  c_diag [MAX_LEN];

  // sample width: low bits of the port taken as they are, or the port zero-extended
  if (SAMPLE_BITS <= SAMPLE_W) begin : g_samp_narrow
    assign samp_x = sample[SAMPLE_BITS-1:0];
  end else begin : g_samp_wide
    assign samp_x = {{(SAMPLE_BITS - SAMPLE_W){1'b0}}, sample};
  end

  // request handshake
  assign adv       = !(res_valid && res_stall);
  assign req_stall = !adv || ((opcode == OP_APPEND) && (busy_cnt != '0));
  assign acc       = req_valid && !req_stall;
  assign app       = acc && (opcode == OP_APPEND);
  assign qry       = acc && (opcode == OP_QUERY);
  assign inject    = qry && ref_closed && (ref_length != '0);

  // reference write control
  assign wr_ctl.en    = app && (ref_closed || (ref_length < LW'(MAX_LEN)));
  assign wr_ctl.clear = app && ref_closed;
  assign wr_idx       = ref_closed ? '0 : ref_length[IW-1:0];

  assign head_wave.valid = inject;
  assign head_wave.first = !query_started;
  assign head_wave.last  = last;

  // chain occupancy
  assign chain_exit    = c_wave[MAX_LEN-1].valid && adv;
  assign busy_cnt_next = busy_cnt + BW'(inject) - BW'(chain_exit);

  // reference and query state
  always_ff @(posedge clk) begin
    if (rst) begin
      ref_length    <= '0;
      ref_closed    <= 1'b0;
      ref_overflow  <= 1'b0;
      query_started <= 1'b0;
      busy_cnt      <= '0;
    end else begin
      busy_cnt <= busy_cnt_next;
      if (app) begin
        ref_closed <= last;
        if (ref_closed) begin
          ref_length    <= LW'(1);
          ref_overflow  <= 1'b0;
          query_started <= 1'b0;
        end else if (ref_length < LW'(MAX_LEN)) begin
          ref_length <= ref_length + 1'b1;
        end else begin
          ref_overflow <= 1'b1;
        end
      end
      if (inject) begin
        query_started <= !last;
      end
    end
  end

  // chain of cells, one per reference sample
  for (genvar j = 0; j < MAX_LEN; j++) begin : g_cell
    wave_t                  w_in;
    logic [SAMPLE_BITS-1:0] d_in;
    cost_t                  l_in;
    cost_t                  g_in;

    if (j == 0) begin : g_head
      assign w_in = head_wave;
      assign d_in = samp_x;
      assign l_in = COST_INF;
      assign g_in = COST_INF;
    end else begin : g_body
      assign w_in = s_wave[j-1];
      assign d_in = s_samp[j-1];
      assign l_in = c_left[j-1];
      assign g_in = c_diag[j-1];
    end

    dtw_cell #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .IDX_W       (IW),
      .CELL_IDX    (j)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .adv       (adv),
      .wr_ctl    (wr_ctl),
      .wr_idx    (wr_idx),
      .wr_data   (samp_x),
      .wave_in   (w_in),
      .samp_in   (d_in),
      .wave_out  (s_wave[j]),
      .samp_out  (s_samp[j]),
      .left_in   (l_in),
      .diag_in   (g_in),
      .cost_wave (c_wave[j]),
      .left_out  (c_left[j]),
      .diag_out  (c_diag[j])
    );
  end

  // finished path cost leaves the end of the chain
  assign res_in.valid = c_wave[MAX_LEN-1].valid && c_wave[MAX_LEN-1].last;
  assign res_in.total = c_left[MAX_LEN-1][COST_W-1:0];
  assign res_in.trunc = ref_overflow || (c_left[MAX_LEN-1][COST_W-1:0] == COST_MAX);

  dtw_isqrt u_isqrt (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .res_in    (res_in),
    .out_valid (res_valid),
    .out_total (dist_sq),
    .out_root  (dist_root),
    .out_trunc (truncated)
  );

  // checks
  `DTW_ASSERT_IMP(a_query_needs_ref, query_started, ref_closed,
                  "query in progress without a closed reference")
  `DTW_ASSERT_IMP(a_busy_bound, 1'b1, busy_cnt <= BW'(MAX_LEN + 2),
                  "chain occupancy count out of range")
  `DTW_ASSERT_IMP(a_root_floor, res_valid,
                  (COST_W'(dist_root) * COST_W'(dist_root)) <= dist_sq,
                  "root squared exceeds path cost")
  `DTW_ASSERT_IMP(a_sat_flag, res_valid && (dist_sq == COST_MAX), truncated,
                  "saturated cost not flagged")
  `DTW_ASSERT_NXT(a_new_ref, app && ref_closed, ref_length == LW'(1),
                  "append after closed reference did not restart it")

endmodule

// File: sim/dtw_distance_engine_test.sv
// self-checking testbench for the dtw distance engine: directed table, then random requests
// depends on dtw_pkg and dtw_distance_engine; results checked against an in-bench row predictor
`timescale 1ns / 1ps

module dtw_distance_engine_test;
  import dtw_pkg::*;

  localparam int MAX_LEN        = DEF_MAX_LEN;
  localparam int LEN_W          = $clog2(MAX_LEN + 1);
  localparam int IDX_W          = $clog2(MAX_LEN);
  localparam int RANDOM_ITEMS   = 540;
  localparam int CALM_AFTER     = 460;
  localparam int HOLD_AT        = 150;
  localparam int HOLD_CYCLES    = 600;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = MAX_LEN + 2 + 24 + 16;

  typedef struct packed {
    logic [COST_W-1:0] dist_sq;
    logic [ROOT_W-1:0] dist_root;
    logic              truncated;
  } path_cost_t;

  // one line of the directed plan; a row repeats reps times, last only on the final one
  typedef struct packed {
    op_t                         op;
    logic signed [SAMPLE_W-1:0]  smp;
    logic                        lst;
    int unsigned                 reps;
    logic                        fixed;
    path_cost_t                  want;
  } plan_row_t;

  typedef struct packed {
    int unsigned item_no;
    path_cost_t  want;
  } pinned_cost_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic                       opcode = OP_APPEND;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       last = 1'b0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [COST_W-1:0]          dist_sq;
  logic [ROOT_W-1:0]          dist_root;
  logic                       truncated;

  // predictor state
  logic signed [SAMPLE_W-1:0] ref_samples [MAX_LEN];
  cost_t                      prev_row [MAX_LEN];
  logic [LEN_W-1:0]           ref_len = '0;
  logic                       ref_done = 1'b0;
  logic                       ref_dropped = 1'b0;
  logic                       query_open = 1'b0;

  path_cost_t   due_costs [$];
  pinned_cost_t pinned_costs [$];
  int unsigned  sent_items = 0;
  int unsigned  items_in = 0;
  int unsigned  useful_items = 0;
  int unsigned  mismatches = 0;
  int unsigned  idle_cycles = 0;
  int unsigned  req_gap_pct = 10;
  logic         calm = 1'b0;
  logic         hold_due = 1'b0;

  // directed requests; fixed rows carry a result that can be read off by hand
  plan_row_t plan [24] = '{
    // query straight after reset, no reference yet
    '{OP_QUERY,  16'sd100,   1'b1, 1,     1'b0, '0},
    // open reference, query against it is ignored
    '{OP_APPEND, 16'sh8000,  1'b0, 1,     1'b0, '0},
    '{OP_QUERY,  16'sd7,     1'b1, 1,     1'b0, '0},
    '{OP_APPEND, 16'sh7FFF,  1'b1, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh7FFF,  1'b0, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh8000,  1'b1, 1,     1'b0, '0},
    // new reference after a closed one, widest single difference
    '{OP_APPEND, 16'sh8000,  1'b1, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh7FFF,  1'b1, 1,     1'b1, '{48'd4294836225, 24'd65535, 1'b0}},
    // next query starts afresh on the same reference
    '{OP_QUERY,  16'sh8000,  1'b1, 1,     1'b1, '{48'd0, 24'd0, 1'b0}},
    '{OP_QUERY,  16'sd0,     1'b1, 3,     1'b0, '0},
    // reference beyond capacity, closing sample still closes it
    '{OP_APPEND, 16'sd0,     1'b1, 300,   1'b0, '0},
    '{OP_QUERY,  16'sd0,     1'b1, 1,     1'b1, '{48'd0, 24'd0, 1'b1}},
    '{OP_QUERY,  16'sd1,     1'b1, 4,     1'b0, '0},
    // alternating bit patterns in the reference
    '{OP_APPEND, -16'sd1,    1'b0, 1,     1'b0, '0},
    '{OP_APPEND, 16'sd1,     1'b0, 1,     1'b0, '0},
    '{OP_APPEND, 16'sh5555,  1'b0, 1,     1'b0, '0},
    '{OP_APPEND, 16'shAAAA,  1'b1, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh7FFF,  1'b0, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh8000,  1'b0, 1,     1'b0, '0},
    '{OP_QUERY,  16'sd0,     1'b1, 1,     1'b0, '0},
    // widest differences piling up down a single column
    '{OP_APPEND, 16'sh8000,  1'b1, 1,     1'b0, '0},
    '{OP_QUERY,  16'sh7FFF,  1'b1, 3,     1'b0, '0},
    // reference filled exactly to capacity
    '{OP_APPEND, 16'sd12345, 1'b1, 256,   1'b0, '0},
    '{OP_QUERY,  -16'sd12345, 1'b1, 2,    1'b0, '0}
  };

  dtw_distance_engine #(
    .MAX_LEN     (MAX_LEN),
    .SAMPLE_BITS (DEF_SAMPLE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .opcode    (opcode),
    .sample    (sample),
    .last      (last),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .dist_sq   (dist_sq),
    .dist_root (dist_root),
    .truncated (truncated)
  );

  always #5 clk = ~clk;

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
  end

  // floored square root, one result bit per step from the top
  function automatic logic [ROOT_W-1:0] floor_root(input logic [COST_W-1:0] v);
    logic [ROOT_W-1:0] r;
    logic [COST_W-1:0] t;
    r = '0;
    for (int b = ROOT_W - 1; b >= 0; b--) begin
      t = COST_W'(r) | (COST_W'(1) << b);
      if (t * t <= v) r = t[ROOT_W-1:0];
    end
    return r;
  endfunction

  // one request through the predictor: reference append, or one cost row per query sample
  task automatic dtw_row_update(input op_t op, input logic signed [SAMPLE_W-1:0] smp,
                                input logic lst, output bit took, output bit produced,
                                output path_cost_t cost);
    cost_t                   diag, left, up, best, cost_here, sq;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W:0]       mag;
    logic [COST_W-1:0]       total;
    took = 1'b1;
    produced = 1'b0;
    cost = '0;
    if (op == OP_APPEND) begin
      if (ref_done) begin
        ref_len = '0;
        ref_dropped = 1'b0;
        ref_done = 1'b0;
        query_open = 1'b0;
      end
      if (ref_len < MAX_LEN) begin
        ref_samples[ref_len[IDX_W-1:0]] = smp;
        ref_len++;
      end else begin
        ref_dropped = 1'b1;
      end
      if (lst) ref_done = 1'b1;
    end else if (!ref_done || ref_len == 0) begin
      took = 1'b0;
    end else begin
      // first row starts from the origin, later rows from the row above
      diag = query_open ? COST_INF : cost_t'(0);
      left = COST_INF;
      for (int j = 0; j < ref_len; j++) begin
        diff = (SAMPLE_W + 1)'(smp) - (SAMPLE_W + 1)'(ref_samples[IDX_W'(j)]);
        mag = diff[SAMPLE_W] ? -diff : diff;
        sq = cost_t'(mag) * cost_t'(mag);
        up = query_open ? prev_row[IDX_W'(j)] : COST_INF;
        best = (up < left) ? up : left;
        if (diag < best) best = diag;
        if (sq >= COST_MAX || best >= COST_MAX) cost_here = cost_t'(COST_MAX);
        else cost_here = sq + best;
        if (cost_here > COST_MAX) cost_here = cost_t'(COST_MAX);
        diag = up;
        prev_row[IDX_W'(j)] = cost_here;
        left = cost_here;
      end
      query_open = 1'b1;
      if (lst) begin
        query_open = 1'b0;
        total = prev_row[IDX_W'(ref_len - 1'b1)][COST_W-1:0];
        cost.dist_sq = total;
        cost.dist_root = floor_root(total);
        cost.truncated = ref_dropped || total == COST_MAX;
        produced = 1'b1;
      end
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return '0;
      3, 4, 5: return SAMPLE_W'($urandom_range(0, 64) - 32);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // offer one request and hold it until taken
  task automatic send_request(input op_t op, input logic signed [SAMPLE_W-1:0] smp,
                              input logic lst);
    if (!calm && req_gap_pct != 0 && $urandom_range(0, 99) < req_gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
    req_valid <= 1'b1;
    opcode    <= op;
    sample    <= smp;
    last      <= lst;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent_items++;
  endtask

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin : scoreboard
    bit         took, produced;
    path_cost_t cost, want;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        dtw_row_update(op_t'(opcode), sample, last, took, produced, cost);
        if (took) useful_items++;
        if (produced) begin
          if (pinned_costs.size() != 0 && pinned_costs[0].item_no == items_in)
            cost = pinned_costs.pop_front().want;
          due_costs.push_back(cost);
        end
        items_in++;
      end
      if (res_valid && !res_stall) begin
        if (due_costs.size() == 0) begin
          $error("unexpected result: dist_sq %0d, dist_root %0d, truncated %0b",
                 dist_sq, dist_root, truncated);
          mismatches++;
        end else begin
          want = due_costs.pop_front();
          if (dist_sq !== want.dist_sq) begin
            $error("dist_sq: expected %0d, actual %0d", want.dist_sq, dist_sq);
            mismatches++;
          end
          if (dist_root !== want.dist_root) begin
            $error("dist_root: expected %0d, actual %0d", want.dist_root, dist_root);
            mismatches++;
          end
          if (truncated !== want.truncated) begin
            $error("truncated: expected %0b, actual %0b", want.truncated, truncated);
            mismatches++;
          end
        end
      end
    end
  end

  // give up when neither side moves for too long
  always @(posedge clk) begin : watchdog
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("dtw_distance_engine_test: FAIL");
        $finish;
      end
    end
  end

  // result side: windows of random stall bursts, one long hold-off to back up the chain
  initial begin : result_side
    int unsigned window, res_gap_pct;
    logic        held;
    window = 0;
    res_gap_pct = 0;
    held = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (window == 0) begin
        case ($urandom_range(0, 2))
          0:       res_gap_pct = 0;
          1:       res_gap_pct = 8;
          default: res_gap_pct = 25;
        endcase
        window = 256;
      end
      window--;
      if (hold_due && !held) begin
        held = 1'b1;
        res_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        res_stall <= 1'b0;
        @(posedge clk);
      end else if (!calm && res_gap_pct != 0 && $urandom_range(0, 99) < res_gap_pct) begin
        res_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        res_stall <= 1'b0;
        @(posedge clk);
      end else begin
        @(posedge clk);
      end
    end
  end

  // request side: directed plan, then references with queries, some noise and broken ones
  initial begin : stimulus
    int unsigned random_base, len, qlen, pick;
    plan_row_t   row;
    while (rst) @(posedge clk);

    foreach (plan[r]) begin
      row = plan[r];
      for (int unsigned k = 0; k < row.reps; k++) begin
        if (row.fixed && k == row.reps - 1)
          pinned_costs.push_back('{sent_items, row.want});
        send_request(row.op, row.smp, row.lst && k == row.reps - 1);
      end
    end

    random_base = useful_items;
    while (useful_items - random_base < RANDOM_ITEMS) begin
      if (useful_items - random_base >= CALM_AFTER) calm = 1'b1;
      if (useful_items - random_base >= HOLD_AT) hold_due = 1'b1;
      case ($urandom_range(0, 2))
        0:       req_gap_pct = 0;
        1:       req_gap_pct = 10;
        default: req_gap_pct = 35;
      endcase
      if ($urandom_range(0, 9) == 0) begin
        // noise: any opcode, any last
        repeat ($urandom_range(1, 3))
          send_request(op_t'($urandom_range(0, 1)), rand_sample(), 1'($urandom_range(0, 1)));
      end else begin
        // mostly short references, a few near or at capacity and a few past it
        pick = $urandom_range(0, 99);
        if (pick < 78)      len = $urandom_range(1, 12);
        else if (pick < 92) len = $urandom_range(13, 64);
        else if (pick < 97) len = $urandom_range(200, MAX_LEN);
        else                len = $urandom_range(MAX_LEN + 1, MAX_LEN + 16);
        // an occasional reference is left open
        for (int unsigned k = 0; k < len; k++)
          send_request(OP_APPEND, rand_sample(), k == len - 1 && $urandom_range(0, 19) != 0);
        repeat ($urandom_range(1, 4)) begin
          qlen = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 10) : $urandom_range(11, 48);
          // an occasional query runs on without its last sample
          for (int unsigned k = 0; k < qlen; k++)
            send_request(OP_QUERY, rand_sample(), k == qlen - 1 && $urandom_range(0, 19) != 0);
        end
      end
    end
    req_valid <= 1'b0;

    // drain, then let a full chain latency pass for stray results
    while (due_costs.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("dtw_distance_engine_test: PASS");
    end else begin
      $display("dtw_distance_engine_test: FAIL");
    end
    $finish;
  end

endmodule
